// ===== sv/rfht_pkg.sv =====
package rfht_pkg;

    // Frame selection
    localparam int FRAME_COUNT = 14;
    localparam int FRAME_W     = 4;
    localparam int FRAME_ROWS  = 2 ** FRAME_W;

    // Stream payload layout
    localparam int EPOCH_W     = 22;
    localparam int POS_W       = 45;
    localparam int IN_EPOCH_LSB = 0;
    localparam int IN_X_LSB    = IN_EPOCH_LSB + EPOCH_W;
    localparam int IN_Y_LSB    = IN_X_LSB + POS_W;
    localparam int IN_Z_LSB    = IN_Y_LSB + POS_W;
    localparam int S_TDATA_W   = ((IN_Z_LSB + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((3 * POS_W + 7) / 8) * 8;

    // Internal widths, sized from the bounds of the parameter table
    localparam int T_W    = 23;              // epoch offset from 2015.0, years * 1024
    localparam int PAR_W  = 12;              // one table entry
    localparam int TR_W   = 36;              // translation, um / 1024
    localparam int DR_W   = 28;              // scale / rotation, table units / 1024
    localparam int HALF_W = 24;              // split point for the wide products
    localparam int CF_W   = 2 * HALF_W;      // scale / rotation coefficient, 2^-64
    localparam int CRD_W  = 2 * HALF_W;      // coordinate inside the datapath, um
    localparam int PP_W   = 2 * HALF_W + 2;  // one partial product
    localparam int ACC_W  = 2 * CF_W;        // exact row sum, um * 2^64
    localparam int T_SH   = 54;              // translation alignment
    localparam int RND_SH = 64;              // fraction bits of the row sum
    localparam int EPOCH_SH = 10;            // * 1024

    // Arithmetic constants
    localparam logic signed [T_W-1:0]  EPOCH_REF = T_W'(2063360);
    localparam logic signed [TR_W-1:0] TR_BASE   = TR_W'(102400);
    localparam logic signed [TR_W-1:0] TR_RATE   = TR_W'(100);
    localparam logic signed [CF_W-1:0] KD_SCALE  = CF_W'(180144);
    localparam logic signed [CF_W-1:0] KR_ROT    = CF_W'(873363);
    localparam logic signed [CRD_W-1:0] OUT_LIMIT = CRD_W'(64'sd10000000000000);
    localparam logic signed [CRD_W-1:0] OUT_LIMIT_NEG = -OUT_LIMIT;

    // Parameter set layout
    localparam int SET_LEN = 14;
    localparam int P_TX  = 0;
    localparam int P_TY  = 1;
    localparam int P_TZ  = 2;
    localparam int P_D   = 3;
    localparam int P_RX  = 4;
    localparam int P_RY  = 5;
    localparam int P_RZ  = 6;
    localparam int P_DTX = 7;
    localparam int P_DTY = 8;
    localparam int P_DTZ = 9;
    localparam int P_DD  = 10;
    localparam int P_DRX = 11;
    localparam int P_DRY = 12;
    localparam int P_DRZ = 13;

    // tx ty tz d rx ry rz | rates; 0.1 mm, 0.01 ppb, 0.01 mas (per year)
    localparam int FRAME_TAB [FRAME_ROWS][SET_LEN] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-14, -9, 14, -42, 0, 0, 0, 0, -1, 2, 0, 0, 0, 0},
        '{2, 10, 33, -29, 0, 0, 0, 0, -1, 1, 3, 0, 0, 0},
        '{27, 1, -14, 65, 0, 0, 0, 3, -1, 1, 3, 0, 0, 0},
        '{-2, 8, -342, 225, 0, 0, 0, 1, 0, -17, 11, 0, 0, 0},
        '{65, -39, -779, 398, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{65, -39, -779, 398, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{65, -39, -779, 398, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{-658, 19, -713, 447, -336, -433, 75, 28, -2, -23, 12, -11, -19, 7},
        '{145, -19, -859, 327, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{265, 121, -919, 467, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{245, 81, -1079, 497, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{295, 321, -1459, 837, 0, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{245, -39, -1699, 1147, 10, 0, 36, 1, -6, -31, 12, 0, 0, 2},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    typedef logic signed [PAR_W-1:0] par_t;
    typedef par_t frame_set_t [SET_LEN];
    typedef logic signed [T_W-1:0]   epoch_off_t;
    typedef logic signed [TR_W-1:0]  tr_t;
    typedef logic signed [CF_W-1:0]  cf_t;
    typedef logic signed [CRD_W-1:0] crd_t;

    // Coefficients of one transform application
    typedef struct packed {
        tr_t tr_x;
        tr_t tr_y;
        tr_t tr_z;
        cf_t cd;
        cf_t cr_x;
        cf_t cr_y;
        cf_t cr_z;
    } coef_t;

    // Parameter set of a frame; unused indexes act as the hub frame.
    // The inverse set is the negated set.
    function automatic frame_set_t frame_lookup(logic [FRAME_W-1:0] idx, logic inv);
        frame_set_t s;
        for (int k = 0; k < SET_LEN; k++)
        begin
            if (int'(idx) >= FRAME_COUNT)
                s[k] = '0;
            else if (inv)
                s[k] = PAR_W'(-FRAME_TAB[idx][k]);
            else
                s[k] = PAR_W'(FRAME_TAB[idx][k]);
        end
        return s;
    endfunction

endpackage

// ===== sv/rfht_rows.sv =====
module rfht_rows (
    input  logic            clk,
    input  logic            en,
    input  rfht_pkg::coef_t coef,
    input  rfht_pkg::crd_t  pos [3],
    output rfht_pkg::crd_t  res [3]
);
    import rfht_pkg::*;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic signed [PP_W-1:0] hh;
        logic signed [PP_W-1:0] hl;
        logic signed [PP_W-1:0] lh;
        logic signed [PP_W-1:0] ll;
    } pp_t;

    // Subtracted terms per row: x row -rz*y, y row -rx*z, z row -ry*x
    localparam logic [2:0] TERM_NEG [3] = '{3'b010, 3'b100, 3'b001};

    // Four narrow partial products of one coefficient times one coordinate
    function automatic pp_t mul_parts(cf_t c, crd_t p);
        logic signed [PP_W-1:0] ch;
        logic signed [PP_W-1:0] cl;
        logic signed [PP_W-1:0] ph;
        logic signed [PP_W-1:0] pl;
        pp_t r;
        ch = PP_W'(signed'(c[CF_W-1:HALF_W]));
        cl = PP_W'(c[HALF_W-1:0]);
        ph = PP_W'(signed'(p[CRD_W-1:HALF_W]));
        pl = PP_W'(p[HALF_W-1:0]);
        r.hh = ch * ph;
        r.hl = ch * pl;
        r.lh = cl * ph;
        r.ll = cl * pl;
        return r;
    endfunction

    cf_t  cf_sel [3][3];
    tr_t  tr_sel [3];
    pp_t  pp_next [3][3];
    pp_t  pp_reg [3][3];
    tr_t  tr1_reg [3];
    crd_t p1_reg [3];
    acc_t prod_next [3][3];
    acc_t prod_reg [3][3];
    tr_t  tr2_reg [3];
    crd_t p2_reg [3];
    acc_t acc_next [3];
    acc_t acc_reg [3];
    crd_t p3_reg [3];
    crd_t res_next [3];
    crd_t res_reg [3];

    // Coefficient matrix; term k of every row multiplies coordinate k
    always_comb
    begin
        cf_sel[0][0] = coef.cd;
        cf_sel[0][1] = coef.cr_z;
        cf_sel[0][2] = coef.cr_y;
        cf_sel[1][0] = coef.cr_z;
        cf_sel[1][1] = coef.cd;
        cf_sel[1][2] = coef.cr_x;
        cf_sel[2][0] = coef.cr_y;
        cf_sel[2][1] = coef.cr_x;
        cf_sel[2][2] = coef.cd;
        tr_sel[0] = coef.tr_x;
        tr_sel[1] = coef.tr_y;
        tr_sel[2] = coef.tr_z;
    end

    // Step 1: partial products
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                pp_next[r][k] = mul_parts(cf_sel[r][k], pos[k]);
    end

    // Step 2: recombine each product exactly
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                prod_next[r][k] = (ACC_W'(pp_reg[r][k].hh) <<< (2 * HALF_W))
                                + ((ACC_W'(pp_reg[r][k].hl) + ACC_W'(pp_reg[r][k].lh))
                                   <<< HALF_W)
                                + ACC_W'(pp_reg[r][k].ll);
    end

    // Step 3: row sum with translation
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = ACC_W'(tr2_reg[r]) <<< T_SH;
            for (int k = 0; k < 3; k++)
            begin
                if (TERM_NEG[r][k])
                    acc_next[r] = acc_next[r] - prod_reg[r][k];
                else
                    acc_next[r] = acc_next[r] + prod_reg[r][k];
            end
        end
    end

    // Step 4: round to whole um, half up, and add to the coordinate
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            res_next[r] = p3_reg[r]
                        + CRD_W'(signed'(acc_reg[r][ACC_W-1:RND_SH]))
                        + CRD_W'(acc_reg[r][RND_SH-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            tr1_reg  <= tr_sel;
            p1_reg   <= pos;
            prod_reg <= prod_next;
            tr2_reg  <= tr1_reg;
            p2_reg   <= p1_reg;
            acc_reg  <= acc_next;
            p3_reg   <= p2_reg;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== sv/reference_frame_helmert_transform.sv =====
// Pipeline: 12 register stages (input, 2 coefficient steps, 2 x 4 row steps, clamp register).
// Throughput: one request per cycle; the whole pipeline holds while the output register
//   is full and m_tready is low.
// Reset: rst_n (async, active low) clears all valid bits and selects frame 0 on both sides.
module reference_frame_helmert_transform (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_index,
    input  logic [rfht_pkg::FRAME_W-1:0]   cfg_wdata,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rfht_pkg::S_TDATA_W-1:0] s_tdata,   // epoch_year, pos_x, pos_y, pos_z
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rfht_pkg::M_TDATA_W-1:0] m_tdata,   // out_x, out_y, out_z
    output logic [0:0]                     m_tuser    // saturated
);
    import rfht_pkg::*;

    localparam logic [0:0] REG_SOURCE_FRAME = 1'b0;
    localparam logic [0:0] REG_TARGET_FRAME = 1'b1;
    localparam int STAGES = 12;
    localparam int LAST   = STAGES - 1;

    typedef logic signed [DR_W-1:0] dr_t;

    typedef struct packed {
        tr_t trb_x;
        tr_t trb_y;
        tr_t trb_z;
        tr_t trm_x;
        tr_t trm_y;
        tr_t trm_z;
        dr_t db;
        dr_t rb_x;
        dr_t rb_y;
        dr_t rb_z;
    } pre_t;

    // Epoch-dependent terms of a set
    function automatic pre_t pre_calc(frame_set_t s, epoch_off_t t);
        pre_t p;
        p.trb_x = TR_W'(s[P_TX]) * TR_BASE;
        p.trb_y = TR_W'(s[P_TY]) * TR_BASE;
        p.trb_z = TR_W'(s[P_TZ]) * TR_BASE;
        p.trm_x = TR_W'(s[P_DTX]) * TR_W'(t);
        p.trm_y = TR_W'(s[P_DTY]) * TR_W'(t);
        p.trm_z = TR_W'(s[P_DTZ]) * TR_W'(t);
        p.db    = (DR_W'(s[P_D]) <<< EPOCH_SH) + DR_W'(s[P_DD]) * DR_W'(t);
        p.rb_x  = (DR_W'(s[P_RX]) <<< EPOCH_SH) + DR_W'(s[P_DRX]) * DR_W'(t);
        p.rb_y  = (DR_W'(s[P_RY]) <<< EPOCH_SH) + DR_W'(s[P_DRY]) * DR_W'(t);
        p.rb_z  = (DR_W'(s[P_RZ]) <<< EPOCH_SH) + DR_W'(s[P_DRZ]) * DR_W'(t);
        return p;
    endfunction

    // Final coefficients: translation in um / 1024, scale and rotation in 2^-64 units
    function automatic coef_t coef_calc(pre_t p);
        coef_t c;
        c.tr_x = p.trb_x + p.trm_x * TR_RATE;
        c.tr_y = p.trb_y + p.trm_y * TR_RATE;
        c.tr_z = p.trb_z + p.trm_z * TR_RATE;
        c.cd   = CF_W'(p.db) * KD_SCALE;
        c.cr_x = CF_W'(p.rb_x) * KR_ROT;
        c.cr_y = CF_W'(p.rb_y) * KR_ROT;
        c.cr_z = CF_W'(p.rb_z) * KR_ROT;
        return c;
    endfunction

    logic [FRAME_W-1:0] source_frame_reg;
    logic [FRAME_W-1:0] target_frame_reg;
    logic [STAGES-1:0]  vld_reg;
    logic               adv;

    epoch_off_t t_next;
    epoch_off_t t0_reg;
    crd_t       pos_next [3];
    crd_t       pos0_reg [3];
    crd_t       pos1_reg [3];
    crd_t       pos2_reg [3];
    frame_set_t src_next;
    frame_set_t tgt_next;
    frame_set_t src0_reg;
    frame_set_t tgt0_reg;
    pre_t       pre_src1_reg;
    pre_t       pre_tgt1_reg;
    coef_t      coef_src2_reg;
    coef_t      coef_tgt2_reg;
    coef_t      tgt_dly_reg [4];
    crd_t       mid [3];
    crd_t       fin [3];
    crd_t       clamp_next [3];
    logic       sat_next;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;
    logic signed [POS_W-1:0] out_z_reg;
    logic       sat_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_frame_reg <= '0;
            target_frame_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SOURCE_FRAME: source_frame_reg <= cfg_wdata;
                REG_TARGET_FRAME: target_frame_reg <= cfg_wdata;
            endcase
        end
    end

    // Pipeline moves as a whole unless the output register is stuck
    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
    end

    // Input unpack, epoch offset and set lookup (source set inverted)
    always_comb
    begin
        t_next = epoch_off_t'(signed'({1'b0, s_tdata[IN_EPOCH_LSB +: EPOCH_W]})) - EPOCH_REF;
        pos_next[0] = CRD_W'(signed'(s_tdata[IN_X_LSB +: POS_W]));
        pos_next[1] = CRD_W'(signed'(s_tdata[IN_Y_LSB +: POS_W]));
        pos_next[2] = CRD_W'(signed'(s_tdata[IN_Z_LSB +: POS_W]));
        src_next = frame_lookup(source_frame_reg, 1'b1);
        tgt_next = frame_lookup(target_frame_reg, 1'b0);
    end

    // Clamp to the output range
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (fin[i] > OUT_LIMIT)
            begin
                clamp_next[i] = OUT_LIMIT;
                sat_next = 1'b1;
            end
            else if (fin[i] < OUT_LIMIT_NEG)
            begin
                clamp_next[i] = OUT_LIMIT_NEG;
                sat_next = 1'b1;
            end
            else
                clamp_next[i] = fin[i];
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg        <= t_next;
            pos0_reg      <= pos_next;
            src0_reg      <= src_next;
            tgt0_reg      <= tgt_next;
            pre_src1_reg  <= pre_calc(src0_reg, t0_reg);
            pre_tgt1_reg  <= pre_calc(tgt0_reg, t0_reg);
            pos1_reg      <= pos0_reg;
            coef_src2_reg <= coef_calc(pre_src1_reg);
            coef_tgt2_reg <= coef_calc(pre_tgt1_reg);
            pos2_reg      <= pos1_reg;
            tgt_dly_reg[0] <= coef_tgt2_reg;
            for (int i = 1; i < 4; i++)
                tgt_dly_reg[i] <= tgt_dly_reg[i-1];
            out_x_reg     <= POS_W'(clamp_next[0]);
            out_y_reg     <= POS_W'(clamp_next[1]);
            out_z_reg     <= POS_W'(clamp_next[2]);
            sat_reg       <= sat_next;
        end
    end

    // Inverse source set, then forward target set
    rfht_rows u_rows_src (
        .clk  (clk),
        .en   (adv),
        .coef (coef_src2_reg),
        .pos  (pos2_reg),
        .res  (mid)
    );

    rfht_rows u_rows_tgt (
        .clk  (clk),
        .en   (adv),
        .coef (tgt_dly_reg[3]),
        .pos  (mid),
        .res  (fin)
    );

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {{(M_TDATA_W - 3 * POS_W){1'b0}}, out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser  = sat_reg;

`ifndef NO_ASSERTIONS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_x_reg <= POS_W'(OUT_LIMIT)) && (out_x_reg >= POS_W'(OUT_LIMIT_NEG))
                  && (out_y_reg <= POS_W'(OUT_LIMIT)) && (out_y_reg >= POS_W'(OUT_LIMIT_NEG))
                  && (out_z_reg <= POS_W'(OUT_LIMIT)) && (out_z_reg >= POS_W'(OUT_LIMIT_NEG)))
        else $error("result outside the clamp range");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sat_reg |-> (out_x_reg == POS_W'(OUT_LIMIT))
                             || (out_x_reg == POS_W'(OUT_LIMIT_NEG))
                             || (out_y_reg == POS_W'(OUT_LIMIT))
                             || (out_y_reg == POS_W'(OUT_LIMIT_NEG))
                             || (out_z_reg == POS_W'(OUT_LIMIT))
                             || (out_z_reg == POS_W'(OUT_LIMIT_NEG)))
        else $error("saturated flag without a clamped coordinate");

    a_valid_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[LAST-1]))
        else $error("result valid without an item in the last row step");
`endif

endmodule
